[rtl/core/iet_pkg.sv]
// Package for the interval endpoint table.
// Holds table sizes, derived widths and the opcode type.
// No dependencies.
package iet_pkg;

    localparam int MAX_INTERVALS = 64;
    localparam int ENDPOINTS     = 2 * MAX_INTERVALS;
    localparam int EP_W          = $clog2(ENDPOINTS);
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = 7;
    localparam int KEY_W         = 8;
    localparam int OPC_W         = 3;
    localparam int GRP_W         = 4;
    localparam int GRP           = 1 << GRP_W;
    localparam int NGRP          = ENDPOINTS / GRP;
    localparam int NGRP_W        = EP_W - GRP_W;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD      = 3'd0,
        OP_BY_LEFT   = 3'd1,
        OP_BY_RIGHT  = 3'd2,
        OP_BY_EITHER = 3'd3,
        OP_BY_INDEX  = 3'd4,
        OP_RPRED     = 3'd5,
        OP_LPRED     = 3'd6
    } t_opcode;

endpackage

[rtl/core/interval_endpoint_table.sv]
// Interval endpoint table: one item at a time, with the start/busy command handshake.
// A load reads the old endpoints of its slot from the interval table as it is accepted, reads
// their owners in S_LD_OWN and writes both tables in S_LD_WR. A lookup by left, right or either
// endpoint that hits reads the owner table, then the interval table in S_OWN; a lookup by index
// reads the interval table alone; both give their word from S_IV. A predecessor search registers
// its two-level priority encoder as it is accepted; in S_PE it shows a miss if no endpoint is
// found, else reads the owner table and goes on like a lookup by endpoint. A lookup that misses
// at once (endpoint key out of range or unowned, index key out of range), a load out of range and
// opcode 7, which is dropped, leave the block idle. All reads are single-port synchronous reads.
// Every query gives one result word on o_result_valid for exactly one cycle, with busy low in
// that cycle; the receiver cannot stall it. A load gives no word. The owner valid bits are
// cleared at reset, so no clearing pass is needed. Depends on iet_pkg.
module interval_endpoint_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [iet_pkg::OPC_W-1:0]  i_opcode,
    input  logic [iet_pkg::KEY_W-1:0]  i_key,
    input  logic [iet_pkg::EP_W-1:0]   i_load_left,
    input  logic [iet_pkg::EP_W-1:0]   i_load_right,
    input  logic [iet_pkg::IDX_W-1:0]  i_load_index,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [iet_pkg::CNT_W-1:0]  i_cfg_interval_count,
    output logic                       o_result_valid,
    output logic                       o_found,
    output logic [iet_pkg::EP_W-1:0]   o_left,
    output logic [iet_pkg::EP_W-1:0]   o_right,
    output logic [iet_pkg::IDX_W-1:0]  o_index
);
    import iet_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_OWN,
        S_LD_WR,
        S_PE,
        S_OWN,
        S_IV
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [ENDPOINTS-1:0] r_lvalid;
    logic [ENDPOINTS-1:0] r_rvalid;

    logic [EP_W-1:0]     r_mem_ivl [MAX_INTERVALS];
    logic [EP_W-1:0]     r_mem_ivr [MAX_INTERVALS];
    logic [IDX_W-1:0]    r_mem_lown [ENDPOINTS];
    logic [IDX_W-1:0]    r_mem_rown [ENDPOINTS];
    logic [EP_W-1:0]     r_ivl_q;
    logic [EP_W-1:0]     r_ivr_q;
    logic [IDX_W-1:0]    r_lo_q;
    logic [IDX_W-1:0]    r_ro_q;

    logic [EP_W-1:0]     r_ld_l;
    logic [EP_W-1:0]     r_ld_r;
    logic [IDX_W-1:0]    r_ld_idx;
    logic                r_use_right;
    logic [IDX_W-1:0]    r_qidx;
    logic [NGRP-1:0]     r_grp_any;
    logic [GRP_W-1:0]    r_grp_hi [NGRP];

    logic                r_res_valid;
    logic                r_found;
    logic [EP_W-1:0]     r_left;
    logic [EP_W-1:0]     r_right;
    logic [IDX_W-1:0]    r_index;

    logic                accept;
    logic [CNT_W-1:0]    n_eff;
    logic [KEY_W-1:0]    two_n;
    logic                ld_ok;
    logic                lk_oor;
    logic                lk_hit_l;
    logic                lk_hit_r;
    logic [KEY_W-1:0]    pr_bound;
    logic [ENDPOINTS-1:0] pr_vec;
    logic [ENDPOINTS-1:0] pr_masked;
    logic [NGRP-1:0]     pr_any;
    logic [GRP_W-1:0]    pr_hi [NGRP];
    logic                pe_hit;
    logic [EP_W-1:0]     pe_addr;
    logic [IDX_W-1:0]    own_sel;

    logic                iv_re;
    logic                iv_we;
    logic [IDX_W-1:0]    iv_raddr;
    logic                own_re;
    logic                own_we;
    logic [EP_W-1:0]     lo_raddr;
    logic [EP_W-1:0]     ro_raddr;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_result_valid = r_res_valid;
    assign o_found        = r_found;
    assign o_left         = r_left;
    assign o_right        = r_right;
    assign o_index        = r_index;

    always_comb begin
        if (r_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_INTERVALS)) begin
            n_eff = CNT_W'(MAX_INTERVALS);
        end else begin
            n_eff = r_count;
        end
    end

    assign two_n = {n_eff, 1'b0};

    assign ld_ok = ({1'b0, i_load_index} < n_eff)
                && ({1'b0, i_load_left} < two_n)
                && ({1'b0, i_load_right} < two_n);

    assign lk_oor   = (i_key >= two_n);
    assign lk_hit_l = (i_opcode != OP_BY_RIGHT) && r_lvalid[i_key[EP_W-1:0]];
    assign lk_hit_r = (i_opcode != OP_BY_LEFT) && r_rvalid[i_key[EP_W-1:0]];

    assign pr_bound = (i_key > two_n) ? two_n : i_key;
    assign pr_vec   = (i_opcode == OP_RPRED) ? r_rvalid : r_lvalid;

    always_comb begin
        for (int e = 0; e < ENDPOINTS; e++) begin
            pr_masked[e] = pr_vec[e] && (KEY_W'(e) < pr_bound);
        end
        for (int g = 0; g < NGRP; g++) begin
            pr_any[g] = |pr_masked[g*GRP +: GRP];
            pr_hi[g]  = '0;
            for (int b = 0; b < GRP; b++) begin
                if (pr_masked[g*GRP + b]) begin
                    pr_hi[g] = GRP_W'(b);
                end
            end
        end
    end

    always_comb begin
        pe_hit  = 1'b0;
        pe_addr = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_grp_any[g]) begin
                pe_hit  = 1'b1;
                pe_addr = {NGRP_W'(g), r_grp_hi[g]};
            end
        end
    end

    assign own_sel = r_use_right ? r_ro_q : r_lo_q;

    assign iv_re  = ((r_state == S_IDLE) && accept) || (r_state == S_OWN);
    assign iv_we  = (r_state == S_LD_WR);
    assign own_re = ((r_state == S_IDLE) && accept) || (r_state == S_LD_OWN)
                 || (r_state == S_PE);
    assign own_we = (r_state == S_LD_WR);

    always_comb begin
        if (r_state == S_OWN) begin
            iv_raddr = own_sel;
        end else if (i_opcode == OP_LOAD) begin
            iv_raddr = i_load_index;
        end else begin
            iv_raddr = i_key[IDX_W-1:0];
        end
    end

    always_comb begin
        unique case (r_state)
            S_LD_OWN: begin
                lo_raddr = r_ivl_q;
                ro_raddr = r_ivr_q;
            end
            S_PE: begin
                lo_raddr = pe_addr;
                ro_raddr = pe_addr;
            end
            default: begin
                lo_raddr = i_key[EP_W-1:0];
                ro_raddr = i_key[EP_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (iv_we) begin
            r_mem_ivl[r_ld_idx] <= r_ld_l;
            r_mem_ivr[r_ld_idx] <= r_ld_r;
        end
        if (iv_re) begin
            r_ivl_q <= r_mem_ivl[iv_raddr];
            r_ivr_q <= r_mem_ivr[iv_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (own_we) begin
            r_mem_lown[r_ld_l] <= r_ld_idx;
            r_mem_rown[r_ld_r] <= r_ld_idx;
        end
        if (own_re) begin
            r_lo_q <= r_mem_lown[lo_raddr];
            r_ro_q <= r_mem_rown[ro_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(MAX_INTERVALS);
            r_lvalid    <= '0;
            r_rvalid    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_interval_count;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_opcode)
                            OP_LOAD: begin
                                r_ld_l   <= i_load_left;
                                r_ld_r   <= i_load_right;
                                r_ld_idx <= i_load_index;
                                if (ld_ok) begin
                                    r_state <= S_LD_OWN;
                                end
                            end
                            OP_BY_LEFT, OP_BY_RIGHT, OP_BY_EITHER: begin
                                if (lk_oor || !(lk_hit_l || lk_hit_r)) begin
                                    r_res_valid <= 1'b1;
                                    r_found     <= 1'b0;
                                    r_left      <= '0;
                                    r_right     <= '0;
                                    r_index     <= '0;
                                end else begin
                                    r_use_right <= !lk_hit_l;
                                    r_state     <= S_OWN;
                                end
                            end
                            OP_BY_INDEX: begin
                                if (i_key >= {1'b0, n_eff}) begin
                                    r_res_valid <= 1'b1;
                                    r_found     <= 1'b0;
                                    r_left      <= '0;
                                    r_right     <= '0;
                                    r_index     <= '0;
                                end else begin
                                    r_qidx  <= i_key[IDX_W-1:0];
                                    r_state <= S_IV;
                                end
                            end
                            OP_RPRED, OP_LPRED: begin
                                r_use_right <= (i_opcode == OP_RPRED);
                                r_grp_any   <= pr_any;
                                r_grp_hi    <= pr_hi;
                                r_state     <= S_PE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LD_OWN: begin
                    r_state <= S_LD_WR;
                end
                S_LD_WR: begin
                    if (r_lvalid[r_ivl_q] && (r_lo_q == r_ld_idx)) begin
                        r_lvalid[r_ivl_q] <= 1'b0;
                    end
                    if (r_rvalid[r_ivr_q] && (r_ro_q == r_ld_idx)) begin
                        r_rvalid[r_ivr_q] <= 1'b0;
                    end
                    r_lvalid[r_ld_l] <= 1'b1;
                    r_rvalid[r_ld_r] <= 1'b1;
                    r_state          <= S_IDLE;
                end
                S_PE: begin
                    if (pe_hit) begin
                        r_state <= S_OWN;
                    end else begin
                        r_res_valid <= 1'b1;
                        r_found     <= 1'b0;
                        r_left      <= '0;
                        r_right     <= '0;
                        r_index     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_OWN: begin
                    r_qidx  <= own_sel;
                    r_state <= S_IV;
                end
                S_IV: begin
                    r_res_valid <= 1'b1;
                    r_found     <= 1'b1;
                    r_left      <= r_ivl_q;
                    r_right     <= r_ivr_q;
                    r_index     <= r_qidx;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_res_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> (o_left == '0 && o_right == '0 && o_index == '0))
        else $error("miss carries nonzero fields");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD_OWN || r_state == S_LD_WR) |=> !o_result_valid)
        else $error("load produced a result");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD_WR) |=> (r_lvalid[$past(r_ld_l)] && r_rvalid[$past(r_ld_r)]))
        else $error("loaded endpoints not marked owned");
`endif

endmodule

[tb/sv/iet_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the interval endpoint table: watches the command, config and result
// channels, keeps its own copy of the owner and slot tables, and compares every result.
// Depends on iet_pkg.
module iet_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [iet_pkg::OPC_W-1:0]    i_opcode,
    input  logic [iet_pkg::KEY_W-1:0]    i_key,
    input  logic [iet_pkg::EP_W-1:0]     i_load_left,
    input  logic [iet_pkg::EP_W-1:0]     i_load_right,
    input  logic [iet_pkg::IDX_W-1:0]    i_load_index,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [iet_pkg::CNT_W-1:0]    i_cfg_interval_count,
    input  logic                         i_result_valid,
    input  logic                         i_found,
    input  logic [iet_pkg::EP_W-1:0]     i_left,
    input  logic [iet_pkg::EP_W-1:0]     i_right,
    input  logic [iet_pkg::IDX_W-1:0]    i_index,
    output int                           o_fail_count,
    output int                           o_pending
);
    import iet_pkg::*;

    typedef struct packed {
        logic             found;
        logic [EP_W-1:0]  left;
        logic [EP_W-1:0]  right;
        logic [IDX_W-1:0] index;
    } t_lookup;

    logic             left_live  [ENDPOINTS];
    logic [IDX_W-1:0] left_own   [ENDPOINTS];
    logic             right_live [ENDPOINTS];
    logic [IDX_W-1:0] right_own  [ENDPOINTS];
    logic [EP_W-1:0]  slot_left  [MAX_INTERVALS];
    logic [EP_W-1:0]  slot_right [MAX_INTERVALS];
    logic [CNT_W-1:0] count_reg;
    t_lookup          pending_lookups [$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch, %s: got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned span();
        if (count_reg == 0) return 1;
        if (count_reg > MAX_INTERVALS) return MAX_INTERVALS;
        return count_reg;
    endfunction

    function automatic t_lookup hit(input int unsigned slot);
        t_lookup res;
        res.found = 1'b1;
        res.left  = slot_left[slot];
        res.right = slot_right[slot];
        res.index = slot[IDX_W-1:0];
        return res;
    endfunction

    function automatic t_lookup nearest_below(input bit by_right, input int unsigned bound);
        int unsigned lim;
        lim = 2 * span();
        if (bound > lim) bound = lim;
        for (int unsigned e = bound; e > 0; e--) begin
            if (by_right && right_live[e-1]) return hit(right_own[e-1]);
            if (!by_right && left_live[e-1]) return hit(left_own[e-1]);
        end
        return '0;
    endfunction

    task automatic store_interval(input logic [EP_W-1:0] l, input logic [EP_W-1:0] r,
                                  input logic [IDX_W-1:0] ix);
        int unsigned n;
        logic [EP_W-1:0] old_l;
        logic [EP_W-1:0] old_r;
        n = span();
        if (ix >= n || l >= 2 * n || r >= 2 * n) return;
        old_l = slot_left[ix];
        old_r = slot_right[ix];
        if (left_live[old_l] && left_own[old_l] == ix) left_live[old_l] = 1'b0;
        if (right_live[old_r] && right_own[old_r] == ix) right_live[old_r] = 1'b0;
        slot_left[ix]  = l;
        slot_right[ix] = r;
        left_live[l]   = 1'b1;
        left_own[l]    = ix;
        right_live[r]  = 1'b1;
        right_own[r]   = ix;
    endtask

    task automatic predict_item(input logic [OPC_W-1:0] code, input logic [KEY_W-1:0] k,
                                input logic [EP_W-1:0] l, input logic [EP_W-1:0] r,
                                input logic [IDX_W-1:0] ix);
        int unsigned n;
        t_lookup res;
        n = span();
        res = '0;
        case (code)
            OP_LOAD: store_interval(l, r, ix);
            OP_BY_LEFT, OP_BY_RIGHT, OP_BY_EITHER: begin
                if (k < 2 * n) begin
                    if (code != OP_BY_RIGHT && left_live[k[EP_W-1:0]])
                        res = hit(left_own[k[EP_W-1:0]]);
                    else if (code != OP_BY_LEFT && right_live[k[EP_W-1:0]])
                        res = hit(right_own[k[EP_W-1:0]]);
                end
                pending_lookups.push_back(res);
            end
            OP_BY_INDEX: begin
                if (k < n) res = hit(k);
                pending_lookups.push_back(res);
            end
            OP_RPRED: pending_lookups.push_back(nearest_below(1'b1, k));
            OP_LPRED: pending_lookups.push_back(nearest_below(1'b0, k));
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_lookup want;
        if (!i_rst_n) begin
            for (int e = 0; e < ENDPOINTS; e++) begin
                left_live[e]  = 1'b0;
                left_own[e]   = '0;
                right_live[e] = 1'b0;
                right_own[e]  = '0;
            end
            for (int s = 0; s < MAX_INTERVALS; s++) begin
                slot_left[s]  = '0;
                slot_right[s] = '0;
            end
            count_reg = CNT_W'(MAX_INTERVALS);
            pending_lookups.delete();
        end else begin
            if (i_result_valid) begin
                if (pending_lookups.size() == 0) begin
                    report_mismatch("result word with nothing pending", 1, 0);
                end else begin
                    want = pending_lookups.pop_front();
                    if (i_found !== want.found) report_mismatch("found", i_found, want.found);
                    if (i_left !== want.left) report_mismatch("left", i_left, want.left);
                    if (i_right !== want.right) report_mismatch("right", i_right, want.right);
                    if (i_index !== want.index) report_mismatch("index", i_index, want.index);
                end
            end
            if (i_start && !i_busy)
                predict_item(i_opcode, i_key, i_load_left, i_load_right, i_load_index);
            if (i_cfg_valid && i_cfg_ready) count_reg = i_cfg_interval_count;
        end
        o_pending <= pending_lookups.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the interval endpoint table testbench: clock, reset, directed and random
// commands, interval count changes, and the verdict. Depends on iet_pkg and iet_checker.
module testbench;
    import iet_pkg::*;

    localparam logic [OPC_W-1:0] OP_UNUSED   = 3'd7;
    localparam int               CYCLE_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OPC_W-1:0]   cmd_opcode = '0;
    logic [KEY_W-1:0]   cmd_key = '0;
    logic [EP_W-1:0]    cmd_left = '0;
    logic [EP_W-1:0]    cmd_right = '0;
    logic [IDX_W-1:0]   cmd_index = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_count = '0;
    logic               res_valid;
    logic               res_found;
    logic [EP_W-1:0]    res_left;
    logic [EP_W-1:0]    res_right;
    logic [IDX_W-1:0]   res_index;
    int                 fail_count;
    int                 pending;

    int unsigned        cur_n = MAX_INTERVALS;
    bit                 slot_loaded [MAX_INTERVALS];
    bit                 calm = 1'b0;
    int                 cycles = 0;

    interval_endpoint_table u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_opcode             (cmd_opcode),
        .i_key                (cmd_key),
        .i_load_left          (cmd_left),
        .i_load_right         (cmd_right),
        .i_load_index         (cmd_index),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_interval_count (cfg_count),
        .o_result_valid       (res_valid),
        .o_found              (res_found),
        .o_left               (res_left),
        .o_right              (res_right),
        .o_index              (res_index)
    );

    iet_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (start),
        .i_busy               (busy),
        .i_opcode             (cmd_opcode),
        .i_key                (cmd_key),
        .i_load_left          (cmd_left),
        .i_load_right         (cmd_right),
        .i_load_index         (cmd_index),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_interval_count (cfg_count),
        .i_result_valid       (res_valid),
        .i_found              (res_found),
        .i_left               (res_left),
        .i_right              (res_right),
        .i_index              (res_index),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_item(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [EP_W-1:0] l, input logic [EP_W-1:0] r,
                             input logic [IDX_W-1:0] ix);
        while (!calm && $urandom_range(99) < 27) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        cmd_opcode <= op;
        cmd_key    <= k;
        cmd_left   <= l;
        cmd_right  <= r;
        cmd_index  <= ix;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (op == OP_LOAD && ix < cur_n && l < 2 * cur_n && r < 2 * cur_n)
            slot_loaded[ix] = 1'b1;
    endtask

    // hold commands until every lookup word is back and the last load has retired
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_count(input logic [CNT_W-1:0] value);
        settle();
        while ($urandom_range(99) < 27) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_count <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (value == 0) cur_n = 1;
        else if (value > MAX_INTERVALS) cur_n = MAX_INTERVALS;
        else cur_n = value;
    endtask

    task automatic random_item();
        int unsigned pick;
        logic [OPC_W-1:0] op;
        logic [KEY_W-1:0] k;
        logic [EP_W-1:0] l;
        logic [EP_W-1:0] r;
        logic [IDX_W-1:0] ix;
        pick = $urandom_range(99);
        k  = KEY_W'($urandom);
        l  = EP_W'($urandom);
        r  = EP_W'($urandom);
        ix = IDX_W'($urandom);
        if (pick < 3) begin
            op = OP_UNUSED;
        end else if (pick < 35) begin
            op = OP_LOAD;
            if ($urandom_range(9) != 0) begin
                ix = IDX_W'($urandom_range(0, cur_n - 1));
                l  = EP_W'($urandom_range(0, 2 * cur_n - 1));
                r  = EP_W'($urandom_range(0, 2 * cur_n - 1));
            end
        end else begin
            op = OPC_W'($urandom_range(OP_BY_LEFT, OP_LPRED));
            if ($urandom_range(4) != 0) k = KEY_W'($urandom_range(0, 2 * cur_n));
            // keep away from slots that were never written
            if (op == OP_BY_INDEX && k < cur_n && !slot_loaded[k[IDX_W-1:0]])
                k = KEY_W'(cur_n);
        end
        send_item(op, k, l, r, ix);
    endtask

    initial begin
        logic [CNT_W-1:0] counts [6];
        counts = '{7'd1, 7'd0, 7'd127, 7'd33, 7'd100, 7'd64};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_LOAD, 0, 0, 127, 0);
        send_item(OP_LOAD, 0, 127, 1, 63);
        send_item(OP_LOAD, 0, 10, 20, 5);
        send_item(OP_BY_LEFT, 0, 0, 0, 0);
        send_item(OP_BY_RIGHT, 127, 0, 0, 0);
        send_item(OP_BY_EITHER, 127, 0, 0, 0);
        send_item(OP_BY_INDEX, 63, 0, 0, 0);
        send_item(OP_BY_INDEX, 64, 0, 0, 0);
        send_item(OP_BY_LEFT, 128, 0, 0, 0);
        send_item(OP_BY_EITHER, 255, 0, 0, 0);
        send_item(OP_RPRED, 255, 0, 0, 0);
        send_item(OP_LPRED, 0, 0, 0, 0);
        send_item(OP_LPRED, 11, 0, 0, 0);
        send_item(OP_LOAD, 0, 10, 30, 6);
        send_item(OP_BY_LEFT, 10, 0, 0, 0);
        send_item(OP_LOAD, 0, 40, 20, 5);
        send_item(OP_BY_RIGHT, 20, 0, 0, 0);
        send_item(OP_BY_INDEX, 5, 0, 0, 0);
        send_item(OP_UNUSED, 0, 0, 0, 0);

        set_count(8);
        send_item(OP_LOAD, 0, 1, 2, 8);
        send_item(OP_LOAD, 0, 16, 3, 2);
        send_item(OP_LOAD, 0, 15, 14, 7);
        send_item(OP_BY_LEFT, 16, 0, 0, 0);
        send_item(OP_BY_INDEX, 7, 0, 0, 0);
        send_item(OP_RPRED, 200, 0, 0, 0);
        for (int i = 0; i < 75; i++) begin
            random_item();
            if (i == 37) settle();
        end

        foreach (counts[p]) begin
            set_count(counts[p]);
            calm = (counts[p] == 7'd127);
            for (int i = 0; i < 62; i++) begin
                random_item();
                if (i == 31) settle();
            end
        end
        calm = 1'b0;

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/iet_pkg.sv
rtl/core/interval_endpoint_table.sv
tb/sv/iet_checker.sv
tb/sv/testbench.sv
